// ----- rtl/dsr_pkg.sv -----
// Shared types and constants for the device sighting ring and aging table.
package dsr_pkg;

    // Default sizes of the sighting ring and the address table.
    localparam int RING_DEPTH_DEF  = 48;
    localparam int TABLE_DEPTH_DEF = 96;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 2'd1;
    localparam logic [31:0] STALE_LIMIT_RST = 32'd60000;

    // Request types.
    localparam logic [1:0] REQ_SIGHT = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_COUNT = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_NEW       = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SELF      = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;
    localparam logic [2:0] ST_POPPED    = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_COUNTED   = 3'd7;

    // Request word.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [47:0]        entry_addr;
        logic signed [7:0]  signal_level;
        logic [31:0]        now_ms;
    } t_req;

    // Result word.
    typedef struct packed {
        logic [2:0]         status;
        logic [47:0]        out_addr;
        logic signed [7:0]  out_level;
        logic [6:0]         live_count;
    } t_rsp;

endpackage

// ----- rtl/device_sighting_ring_and_aging_table.sv -----
// Top level of the device sighting ring and aging address table.
//
// Usage: a request word is taken on i_req at a rising edge where start is high
// and busy is low. Request types are sighting, pop oldest sighting, and expire
// and count. Every request except the unused type three gives exactly one
// result word on o_result, shown for one cycle with o_done high. The receiver
// cannot stall; it must take the word in that cycle.
// Timing: a dropped sighting (zero or own address) gives its result in the cycle
// after the request is taken and leaves busy low. A pop holds busy for one
// cycle while the ring word is read, and its result follows right after. A stored
// sighting and a count request walk the table memory one entry per cycle through
// its single read port, so busy stays high until the last entry is compared and
// the result follows right after; a sighting that finds its address early ends
// early. A new request may be taken in the cycle that shows a result.
// Configuration words go through the i_cfg_* channel, which is always ready, and
// the user must write them only while the block is idle; the block does not enforce it.
// Reset: ring pointers, fill and all table valid bits clear at once, the control
// registers return to their reset values, and no reset pass is needed.
module device_sighting_ring_and_aging_table #(
    parameter int RING_DEPTH  = dsr_pkg::RING_DEPTH_DEF,
    parameter int TABLE_DEPTH = dsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dsr_pkg::t_req                  i_req,
    output logic                           o_done,
    output dsr_pkg::t_rsp                  o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [47:0]                    i_cfg_data
);

    localparam int RW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_UPS  = 2'd2;
    localparam logic [1:0] S_EXP  = 2'd3;

    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  level;
    } t_ring_ent;

    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  level;
        logic [31:0]        seen;
    } t_tab_ent;

    // Memories.
    t_ring_ent ring_mem [RING_DEPTH];
    t_tab_ent  tab_mem  [TABLE_DEPTH];

    // Registers and their next values.
    logic [1:0]             r_state, n_state;
    logic [47:0]            r_self_addr, n_self_addr;
    logic [31:0]            r_stale_limit, n_stale_limit;
    logic [RW-1:0]          r_head, n_head;
    logic [RW-1:0]          r_tail, n_tail;
    logic [FW-1:0]          r_fill, n_fill;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    dsr_pkg::t_req          r_cur, n_cur;
    logic [TW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_issue_on, n_issue_on;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [TW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_have_free, n_have_free;
    logic [TW-1:0]          r_free_idx, n_free_idx;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_done, n_done;
    dsr_pkg::t_rsp          r_rsp, n_rsp;
    t_ring_ent              r_ring_q;
    t_tab_ent               r_tab_q;

    // Memory access controls.
    logic          ring_we, ring_re;
    t_ring_ent     ring_wd;
    logic          tab_we, tab_re;
    logic [TW-1:0] tab_wa;
    t_tab_ent      tab_wd;

    // Compare stage terms.
    logic          ent_valid, ent_hit, cmp_last, ent_stale;
    logic [31:0]   ent_age;
    logic          free_eff;
    logic [TW-1:0] free_idx_eff;
    logic [CW-1:0] cnt_eff;

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_rsp;
    assign o_cfg_ready = 1'b1;

    // Entry read last cycle, checked against the current request.
    always_comb begin
        ent_valid    = r_cmp_vld && r_valid[r_cmp_idx];
        ent_hit      = ent_valid && (r_tab_q.addr == r_cur.entry_addr);
        cmp_last     = (r_cmp_idx == TW'(TABLE_DEPTH - 1));
        ent_age      = r_cur.now_ms - r_tab_q.seen;
        ent_stale    = (ent_age > r_stale_limit);
        free_eff     = r_have_free || (r_cmp_vld && !r_valid[r_cmp_idx]);
        free_idx_eff = r_have_free ? r_free_idx : r_cmp_idx;
        cnt_eff      = (ent_valid && !ent_stale) ? r_cnt + CW'(1) : r_cnt;
    end

    // Main sequencer.
    always_comb begin
        n_state       = r_state;
        n_self_addr   = r_self_addr;
        n_stale_limit = r_stale_limit;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_valid       = r_valid;
        n_cur         = r_cur;
        n_rd_idx      = r_rd_idx;
        n_issue_on    = r_issue_on;
        n_cmp_vld     = r_issue_on;
        n_cmp_idx     = r_rd_idx;
        n_have_free   = r_have_free;
        n_free_idx    = r_free_idx;
        n_cnt         = r_cnt;
        n_done        = 1'b0;
        n_rsp         = r_rsp;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        ring_wd       = '{addr: i_req.entry_addr, level: i_req.signal_level};
        tab_we        = 1'b0;
        tab_re        = r_issue_on;
        tab_wa        = r_cmp_idx;
        tab_wd        = '{addr: r_cur.entry_addr, level: r_cur.signal_level,
                          seen: r_cur.now_ms};

        // Configuration writes.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dsr_pkg::CFG_SELF_ADDR:   n_self_addr   = i_cfg_data;
                dsr_pkg::CFG_STALE_LIMIT: n_stale_limit = i_cfg_data[31:0];
                default: ;
            endcase
        end

        // Table read issue, one entry per cycle.
        if (r_issue_on) begin
            if (r_rd_idx == TW'(TABLE_DEPTH - 1)) begin
                n_issue_on = 1'b0;
            end else begin
                n_rd_idx = r_rd_idx + TW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cur = i_req;
                    unique case (i_req.req_type)
                        dsr_pkg::REQ_SIGHT: begin
                            if (i_req.entry_addr == 48'd0) begin
                                n_done = 1'b1;
                                n_rsp = '0;
                                n_rsp.status = dsr_pkg::ST_ZERO;
                            end else if (i_req.entry_addr == r_self_addr) begin
                                n_done = 1'b1;
                                n_rsp = '0;
                                n_rsp.status = dsr_pkg::ST_SELF;
                            end else begin
                                // Push into the ring, dropping the oldest when full.
                                ring_we = 1'b1;
                                n_head = (r_head == RW'(RING_DEPTH - 1)) ?
                                         '0 : r_head + RW'(1);
                                if (r_fill == FW'(RING_DEPTH)) begin
                                    n_tail = (r_tail == RW'(RING_DEPTH - 1)) ?
                                             '0 : r_tail + RW'(1);
                                end else begin
                                    n_fill = r_fill + FW'(1);
                                end
                                n_state     = S_UPS;
                                n_issue_on  = 1'b1;
                                n_rd_idx    = '0;
                                n_have_free = 1'b0;
                            end
                        end
                        dsr_pkg::REQ_POP: begin
                            if (r_fill == '0) begin
                                n_done = 1'b1;
                                n_rsp = '0;
                                n_rsp.status = dsr_pkg::ST_EMPTY;
                            end else begin
                                ring_re = 1'b1;
                                n_tail = (r_tail == RW'(RING_DEPTH - 1)) ?
                                         '0 : r_tail + RW'(1);
                                n_fill  = r_fill - FW'(1);
                                n_state = S_POP;
                            end
                        end
                        dsr_pkg::REQ_COUNT: begin
                            n_state    = S_EXP;
                            n_issue_on = 1'b1;
                            n_rd_idx   = '0;
                            n_cnt      = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_done          = 1'b1;
                n_rsp           = '0;
                n_rsp.status    = dsr_pkg::ST_POPPED;
                n_rsp.out_addr  = r_ring_q.addr;
                n_rsp.out_level = r_ring_q.level;
                n_state         = S_IDLE;
            end
            S_UPS: begin
                if (r_cmp_vld) begin
                    if (ent_hit) begin
                        // Refresh the matching entry and stop the walk.
                        tab_we       = 1'b1;
                        n_done       = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = dsr_pkg::ST_REFRESHED;
                        n_state      = S_IDLE;
                        n_issue_on   = 1'b0;
                        n_cmp_vld    = 1'b0;
                    end else begin
                        n_have_free = free_eff;
                        n_free_idx  = free_idx_eff;
                        if (cmp_last) begin
                            n_done  = 1'b1;
                            n_rsp   = '0;
                            n_state = S_IDLE;
                            if (free_eff) begin
                                tab_we                = 1'b1;
                                tab_wa                = free_idx_eff;
                                n_valid[free_idx_eff] = 1'b1;
                                n_rsp.status          = dsr_pkg::ST_NEW;
                            end else begin
                                n_rsp.status = dsr_pkg::ST_FULL;
                            end
                        end
                    end
                end
            end
            S_EXP: begin
                if (r_cmp_vld) begin
                    if (ent_valid && ent_stale) begin
                        n_valid[r_cmp_idx] = 1'b0;
                    end
                    n_cnt = cnt_eff;
                    if (cmp_last) begin
                        n_done           = 1'b1;
                        n_rsp            = '0;
                        n_rsp.status     = dsr_pkg::ST_COUNTED;
                        n_rsp.live_count = 7'(cnt_eff);
                        n_state          = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_self_addr   <= '0;
            r_stale_limit <= dsr_pkg::STALE_LIMIT_RST;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_valid       <= '0;
            r_issue_on    <= 1'b0;
            r_cmp_vld     <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_self_addr   <= n_self_addr;
            r_stale_limit <= n_stale_limit;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_fill        <= n_fill;
            r_valid       <= n_valid;
            r_issue_on    <= n_issue_on;
            r_cmp_vld     <= n_cmp_vld;
            r_done        <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_cnt       <= n_cnt;
        r_rsp       <= n_rsp;
    end

    // Sighting ring memory.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_head] <= ring_wd;
        end
        if (ring_re) begin
            r_ring_q <= ring_mem[r_tail];
        end
    end

    // Address table memory.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[tab_wa] <= tab_wd;
        end
        if (tab_re) begin
            r_tab_q <= tab_mem[r_rd_idx];
        end
    end

    // A result word is only shown once the block is idle again.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !busy)
        else $error("result shown while busy");

    // Ring fill never passes the ring size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= FW'(RING_DEPTH))
        else $error("ring fill out of range");

    // When the ring is empty or full, head and tail meet.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FW'(RING_DEPTH)) |-> (r_head == r_tail))
        else $error("ring pointers disagree with fill");

    // The compare stage only runs during a table walk.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_UPS || r_state == S_EXP))
        else $error("table compare outside a walk");

    // A popped word always follows the pop state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rsp.status == dsr_pkg::ST_POPPED) |-> ($past(r_state) == S_POP))
        else $error("popped word without a ring read");

endmodule

// ----- dv/device_sighting_ring_and_aging_table_tb.sv -----
// Self-checking testbench for the device sighting ring and aging address table.
module device_sighting_ring_and_aging_table_tb;

    localparam int RING_N = dsr_pkg::RING_DEPTH_DEF;
    localparam int TABLE_N = dsr_pkg::TABLE_DEPTH_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE_CYCLES = TABLE_N + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RESULT_TARGET = 470;
    localparam int QUIET_AFTER = 390;

    // One row of the directed stimulus: a register write or a request word.
    typedef struct {
        bit             is_cfg;
        logic [1:0]     cfg_idx;
        logic [47:0]    cfg_val;
        dsr_pkg::t_req  word;
        bit             typed;
        dsr_pkg::t_rsp  want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    dsr_pkg::t_req                 i_req = '0;
    logic                          o_done;
    dsr_pkg::t_rsp                 o_result;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [dsr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [47:0]                   i_cfg_data = '0;

    // Predictor state: the sighting ring, the address table and the registers.
    logic [47:0]        sight_ring_addr [RING_N];
    logic signed [7:0]  sight_ring_lvl [RING_N];
    int                 ring_wr = 0;
    int                 ring_rd = 0;
    int                 ring_count = 0;
    logic [47:0]        dev_addr [TABLE_N];
    logic [31:0]        dev_seen [TABLE_N];
    bit                 dev_valid [TABLE_N];
    logic [47:0]        own_addr = '0;
    logic [31:0]        age_limit = dsr_pkg::STALE_LIMIT_RST;

    dsr_pkg::t_rsp pending_results [$];
    t_stim_row     directed_rows [$];
    logic [47:0]   addr_pool [128];
    logic [31:0]   clock_ms = '0;
    int            n_results = 0;
    int            err_count = 0;
    int            cycles = 0;
    bit            gaps_on = 1'b0;

    device_sighting_ring_and_aging_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Works out the result of one accepted request and updates the state.
    // Returns zero for the unused request type, which gives no result.
    function automatic bit predict_result(input dsr_pkg::t_req r,
                                          output dsr_pkg::t_rsp y);
        int hit;
        int free;
        int live;
        logic [31:0] age;
        y = '0;
        hit = -1;
        free = -1;
        live = 0;
        case (r.req_type)
            dsr_pkg::REQ_SIGHT: begin
                if (r.entry_addr == '0) begin
                    y.status = dsr_pkg::ST_ZERO;
                end else if (r.entry_addr == own_addr) begin
                    y.status = dsr_pkg::ST_SELF;
                end else begin
                    // Push to the ring; a full ring drops its oldest word.
                    sight_ring_addr[ring_wr] = r.entry_addr;
                    sight_ring_lvl[ring_wr] = r.signal_level;
                    ring_wr = (ring_wr + 1) % RING_N;
                    if (ring_count < RING_N) ring_count++;
                    else ring_rd = (ring_rd + 1) % RING_N;
                    // Refresh a matching entry, else take the lowest free slot.
                    for (int i = 0; i < TABLE_N; i++) begin
                        if (dev_valid[i] && dev_addr[i] == r.entry_addr) begin
                            hit = i;
                            break;
                        end
                        if (!dev_valid[i] && free < 0) free = i;
                    end
                    if (hit >= 0) begin
                        dev_seen[hit] = r.now_ms;
                        y.status = dsr_pkg::ST_REFRESHED;
                    end else if (free < 0) begin
                        y.status = dsr_pkg::ST_FULL;
                    end else begin
                        dev_addr[free] = r.entry_addr;
                        dev_seen[free] = r.now_ms;
                        dev_valid[free] = 1'b1;
                        y.status = dsr_pkg::ST_NEW;
                    end
                end
            end
            dsr_pkg::REQ_POP: begin
                if (ring_count == 0) begin
                    y.status = dsr_pkg::ST_EMPTY;
                end else begin
                    y.out_addr = sight_ring_addr[ring_rd];
                    y.out_level = sight_ring_lvl[ring_rd];
                    ring_rd = (ring_rd + 1) % RING_N;
                    ring_count--;
                    y.status = dsr_pkg::ST_POPPED;
                end
            end
            dsr_pkg::REQ_COUNT: begin
                // Ages wrap modulo 2^32; entries older than the limit expire.
                for (int i = 0; i < TABLE_N; i++) begin
                    if (dev_valid[i]) begin
                        age = r.now_ms - dev_seen[i];
                        if (age > age_limit) dev_valid[i] = 1'b0;
                        else live++;
                    end
                end
                y.status = dsr_pkg::ST_COUNTED;
                y.live_count = 7'(live);
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [47:0] rand_addr();
        return {16'($urandom_range(0, 65535)), 32'($urandom)};
    endfunction

    // Builds a request word with a random level at the running time.
    function automatic dsr_pkg::t_req make_req(input logic [1:0] kind,
                                               input logic [47:0] addr);
        dsr_pkg::t_req r;
        r.req_type = kind;
        r.entry_addr = addr;
        r.signal_level = 8'($urandom_range(0, 255));
        r.now_ms = clock_ms;
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    // Presents one request word and holds it until the block takes it.
    task automatic issue(input dsr_pkg::t_req r, input bit typed,
                         input dsr_pkg::t_rsp want);
        dsr_pkg::t_rsp predicted;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        if (predict_result(r, predicted)) begin
            pending_results.push_back(typed ? want : predicted);
            n_results++;
        end
    endtask

    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && n_results < QUIET_AFTER && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 14));
    endtask

    // Waits until every result is in, then lets an ignored word finish too.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == dsr_pkg::CFG_SELF_ADDR) own_addr = val;
        else if (idx == dsr_pkg::CFG_STALE_LIMIT) age_limit = val[31:0];
    endtask

    task automatic add_req(input logic [1:0] kind, input logic [47:0] addr,
                           input logic signed [7:0] lvl, input logic [31:0] now,
                           input bit typed, input logic [2:0] st, input logic [6:0] cnt);
        t_stim_row row;
        row = '{default: '0};
        row.word.req_type = kind;
        row.word.entry_addr = addr;
        row.word.signal_level = lvl;
        row.word.now_ms = now;
        row.typed = typed;
        row.want.status = st;
        row.want.live_count = cnt;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [47:0] val);
        t_stim_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        directed_rows.push_back(row);
    endtask

    // Each result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        dsr_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result word: status %0d addr %h",
                                     o_result.status, o_result.out_addr));
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.out_addr !== want.out_addr
                        || o_result.out_level !== want.out_level
                        || o_result.live_count !== want.live_count) begin
                    note_error($sformatf(
                        "mismatch: expected st %0d addr %h lvl %0d cnt %0d, got %0d %h %0d %0d",
                        want.status, want.out_addr, want.out_level, want.live_count,
                        o_result.status, o_result.out_addr, o_result.out_level,
                        o_result.live_count));
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_stim_row row;
        dsr_pkg::t_req r;
        int scen;
        int nb;
        int sel;
        logic [47:0] val;

        for (int i = 0; i < TABLE_N; i++) dev_valid[i] = 1'b0;
        for (int i = 0; i < 128; i++) begin
            addr_pool[i] = rand_addr();
            if (addr_pool[i] == '0) addr_pool[i] = 48'h1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty ring and table, zero and own address, field
        // extremes, expiry at and just past the limit, time wrap, unused type.
        add_req(dsr_pkg::REQ_POP, '0, 8'sd0, '0, 1'b1, dsr_pkg::ST_EMPTY, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, '0, 1'b1, dsr_pkg::ST_COUNTED, '0);
        add_req(dsr_pkg::REQ_SIGHT, '0, -8'sd128, '0, 1'b1, dsr_pkg::ST_ZERO, '0);
        add_req(dsr_pkg::REQ_SIGHT, ADDR_MAX, 8'sd127, 32'hFFFF_FFFF, 1'b1,
                dsr_pkg::ST_NEW, '0);
        add_req(dsr_pkg::REQ_SIGHT, ADDR_MAX, -8'sd128, '0, 1'b1,
                dsr_pkg::ST_REFRESHED, '0);
        add_req(dsr_pkg::REQ_SIGHT, 48'h1, 8'sd0, '0, 1'b1, dsr_pkg::ST_NEW, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, 32'd60000, 1'b0, dsr_pkg::ST_COUNTED, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, 32'd60001, 1'b0, dsr_pkg::ST_COUNTED, '0);
        add_req(REQ_UNUSED, ADDR_MAX, 8'sd127, 32'hFFFF_FFFF, 1'b0,
                dsr_pkg::ST_COUNTED, '0);
        add_req(dsr_pkg::REQ_POP, '0, 8'sd0, '0, 1'b0, dsr_pkg::ST_POPPED, '0);
        add_req(dsr_pkg::REQ_POP, '0, 8'sd0, '0, 1'b0, dsr_pkg::ST_POPPED, '0);
        add_req(dsr_pkg::REQ_POP, '0, 8'sd0, '0, 1'b0, dsr_pkg::ST_POPPED, '0);
        add_req(dsr_pkg::REQ_POP, '0, 8'sd0, '0, 1'b1, dsr_pkg::ST_EMPTY, '0);
        add_cfg(dsr_pkg::CFG_SELF_ADDR, 48'h1234_5678_9ABC);
        add_req(dsr_pkg::REQ_SIGHT, 48'h1234_5678_9ABC, 8'sd5, 32'd100, 1'b1,
                dsr_pkg::ST_SELF, '0);
        add_req(dsr_pkg::REQ_SIGHT, '0, 8'sd5, 32'd100, 1'b1, dsr_pkg::ST_ZERO, '0);
        add_cfg(dsr_pkg::CFG_STALE_LIMIT, 48'd0);
        add_req(dsr_pkg::REQ_SIGHT, 48'h5, 8'sd127, 32'd100, 1'b0, dsr_pkg::ST_NEW, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, 32'd100, 1'b0, dsr_pkg::ST_COUNTED, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, 32'd101, 1'b0, dsr_pkg::ST_COUNTED, '0);
        add_cfg(dsr_pkg::CFG_STALE_LIMIT, 48'hFFFF_FFFF);
        add_req(dsr_pkg::REQ_SIGHT, 48'h6, -8'sd1, 32'd10, 1'b0, dsr_pkg::ST_NEW, '0);
        add_req(dsr_pkg::REQ_COUNT, '0, 8'sd0, 32'd9, 1'b0, dsr_pkg::ST_COUNTED, '0);
        add_cfg(dsr_pkg::CFG_SELF_ADDR, ADDR_MAX);
        add_req(dsr_pkg::REQ_SIGHT, ADDR_MAX, 8'sd0, '0, 1'b1, dsr_pkg::ST_SELF, '0);
        add_cfg(dsr_pkg::CFG_SELF_ADDR, 48'd0);
        add_cfg(dsr_pkg::CFG_STALE_LIMIT, 48'(dsr_pkg::STALE_LIMIT_RST));

        gaps_on = 1'b1;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.is_cfg) begin
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                issue(row.word, row.typed, row.want);
                maybe_gap();
            end
        end

        // Random scenarios: table fills, pop bursts, mixed traffic, new settings.
        while (n_results < RESULT_TARGET) begin
            scen = $urandom_range(0, 9);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (scen == 0) begin
                // New register settings, extremes among them.
                case ($urandom_range(0, 4))
                    0: val = 48'd0;
                    1: val = 48'hFFFF_FFFF;
                    2: val = 48'(dsr_pkg::STALE_LIMIT_RST);
                    3: val = 48'($urandom_range(1, 3000));
                    default: val = 48'($urandom);
                endcase
                write_reg(dsr_pkg::CFG_STALE_LIMIT, val);
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 3))
                        0: val = 48'd0;
                        1: val = ADDR_MAX;
                        2: val = addr_pool[$urandom_range(0, 15)];
                        default: val = rand_addr();
                    endcase
                    write_reg(dsr_pkg::CFG_SELF_ADDR, val);
                end
            end else if (scen <= 2) begin
                // Burst of sightings from the wide pool: fills ring and table.
                nb = $urandom_range(20, 110);
                for (int k = 0; k < nb; k++) begin
                    r = make_req(dsr_pkg::REQ_SIGHT, addr_pool[$urandom_range(0, 127)]);
                    clock_ms += $urandom_range(0, 50);
                    issue(r, 1'b0, '0);
                    maybe_gap();
                end
            end else if (scen <= 4) begin
                nb = $urandom_range(1, 60);
                for (int k = 0; k < nb; k++) begin
                    issue(make_req(dsr_pkg::REQ_POP, rand_addr()), 1'b0, '0);
                    maybe_gap();
                end
            end else begin
                // Mixed traffic with refreshes, expiry and odd words.
                nb = $urandom_range(10, 40);
                for (int k = 0; k < nb; k++) begin
                    sel = $urandom_range(0, 19);
                    if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
                    if (sel < 9)
                        r = make_req(dsr_pkg::REQ_SIGHT, addr_pool[$urandom_range(0, 15)]);
                    else if (sel < 13) r = make_req(dsr_pkg::REQ_POP, rand_addr());
                    else if (sel < 16) r = make_req(dsr_pkg::REQ_COUNT, rand_addr());
                    else if (sel == 16) r = make_req(dsr_pkg::REQ_SIGHT, '0);
                    else if (sel == 17) r = make_req(dsr_pkg::REQ_SIGHT, own_addr);
                    else if (sel == 18) r = make_req(dsr_pkg::REQ_SIGHT, rand_addr());
                    else r = make_req(REQ_UNUSED, rand_addr());
                    if (sel == 19) r.now_ms = $urandom;
                    clock_ms += $urandom_range(0, 3000);
                    issue(r, 1'b0, '0);
                    maybe_gap();
                end
            end
        end

        quiesce();
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dsr_pkg.sv
rtl/device_sighting_ring_and_aging_table.sv
dv/device_sighting_ring_and_aging_table_tb.sv
